>>> sv/window_rate_draft_length_ctrl_top_macros.svh
// Assertion macros shared by the checker of the speculation-length controller.
// All macros sample on aclk and are disabled while aresetn is low.
`ifndef WINDOW_RATE_DRAFT_LENGTH_CTRL_TOP_MACROS_SVH
`define WINDOW_RATE_DRAFT_LENGTH_CTRL_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRDL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define WRDL_ASSERT_DELAY(label, ante, n, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

>>> sv/wrdl_pkg.sv
// Package of the speculation-length controller: widths, register codes,
// reset values and the structs passed between its modules. No dependencies.
package wrdl_pkg;

    localparam int WINDOW_LEN = 24;

    localparam int CNT_W  = 4;
    localparam int K_W    = 4;
    localparam int WARM_W = 8;
    localparam int PCT_W  = 7;
    localparam int DIR_W  = 2;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 8;

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = $clog2(((1 << CNT_W) - 1) * WINDOW_LEN + 1);
    localparam int PROD_W = SUM_W + PCT_W;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
    localparam logic [WARM_W-1:0] WARM_MAX  = '1;
    localparam logic [PCT_W-1:0]  PCT_HUNDRED = PCT_W'(100);

    localparam logic [IDX_W-1:0] REG_K_MIN     = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_K_MAX     = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_K_START   = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_WARMUP    = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_RAISE_PCT = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_LOWER_PCT = IDX_W'(5);

    localparam logic [K_W-1:0]    K_MIN_RST     = K_W'(2);
    localparam logic [K_W-1:0]    K_MAX_RST     = K_W'(12);
    localparam logic [K_W-1:0]    K_START_RST   = K_W'(2);
    localparam logic [WARM_W-1:0] WARMUP_RST    = WARM_W'(32);
    localparam logic [PCT_W-1:0]  RAISE_PCT_RST = PCT_W'(85);
    localparam logic [PCT_W-1:0]  LOWER_PCT_RST = PCT_W'(55);

    typedef enum logic [DIR_W-1:0] {
        DIR_SAME = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        logic [K_W-1:0]    k_min;
        logic [K_W-1:0]    k_max;
        logic [K_W-1:0]    k_start;
        logic [WARM_W-1:0] warmup_tokens;
        logic [PCT_W-1:0]  raise_pct;
        logic [PCT_W-1:0]  lower_pct;
    } cfg_t;

    typedef struct packed {
        logic           load;
        logic [K_W-1:0] value;
    } k_load_t;

    typedef struct packed {
        logic             valid;
        logic             adjust_en;
        logic [SUM_W-1:0] prop_sum;
        logic [SUM_W-1:0] acc_sum;
    } win_status_t;

endpackage

>>> sv/window_rate_draft_length_ctrl_top.sv
// Channel  | Direction | Ports                                    | Word
// ---------+-----------+------------------------------------------+-----------------------------
// s_       | in        | s_valid, s_ready                         | s_proposed, s_accepted
// m_       | out       | m_valid, m_ready                         | m_k_now, m_direction
// cfg_     | in        | cfg_valid, cfg_ready                     | cfg_index, cfg_data
//
// A word passes the window stage, the sum stage and the result register in that order.
// One word can enter every cycle while the result channel does not stall. The window memory
// is read when a word enters and written back as the word leaves the window stage; the length
// comparison feeds the result register. Reset is synchronous and active low; no clearing pass
// is needed after it. A stalled result holds only the stages behind it that are full.
// Top level of the speculation-length controller; depends on wrdl_pkg,
// wrdl_cfg_regs, wrdl_window and wrdl_adjust.
module window_rate_draft_length_ctrl_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [wrdl_pkg::CNT_W-1:0]  s_proposed,
    input  logic [wrdl_pkg::CNT_W-1:0]  s_accepted,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [wrdl_pkg::K_W-1:0]    m_k_now,
    output logic [wrdl_pkg::DIR_W-1:0]  m_direction,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wrdl_pkg::IDX_W-1:0]  cfg_index,
    input  logic [wrdl_pkg::DATA_W-1:0] cfg_data
);

    wrdl_pkg::cfg_t        cfg;
    wrdl_pkg::k_load_t     k_load;
    wrdl_pkg::win_status_t status;
    logic                  adj_ready;

    wrdl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .k_load    (k_load)
    );

    wrdl_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_proposed (s_proposed),
        .s_accepted (s_accepted),
        .cfg        (cfg),
        .adj_ready  (adj_ready),
        .status     (status)
    );

    wrdl_adjust u_adjust (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .status      (status),
        .cfg         (cfg),
        .k_load      (k_load),
        .adj_ready   (adj_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_k_now     (m_k_now),
        .m_direction (m_direction)
    );

endmodule

>>> sv/wrdl_cfg_regs.sv
// Configuration register file of the speculation-length controller.
// Depends on wrdl_pkg; signals a reload of the length on a k_start write.
module wrdl_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wrdl_pkg::IDX_W-1:0]  cfg_index,
    input  logic [wrdl_pkg::DATA_W-1:0] cfg_data,
    output wrdl_pkg::cfg_t              cfg,
    output wrdl_pkg::k_load_t           k_load
);

    wrdl_pkg::cfg_t cfg_reg;
    wrdl_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next     = cfg_reg;
        k_load.load  = 1'b0;
        k_load.value = cfg_data[wrdl_pkg::K_W-1:0];
        if (wr_en) begin
            unique case (cfg_index)
                wrdl_pkg::REG_K_MIN: begin
                    cfg_next.k_min = cfg_data[wrdl_pkg::K_W-1:0];
                end
                wrdl_pkg::REG_K_MAX: begin
                    cfg_next.k_max = cfg_data[wrdl_pkg::K_W-1:0];
                end
                wrdl_pkg::REG_K_START: begin
                    cfg_next.k_start = cfg_data[wrdl_pkg::K_W-1:0];
                    k_load.load      = 1'b1;
                end
                wrdl_pkg::REG_WARMUP: begin
                    cfg_next.warmup_tokens = cfg_data[wrdl_pkg::WARM_W-1:0];
                end
                wrdl_pkg::REG_RAISE_PCT: begin
                    cfg_next.raise_pct = cfg_data[wrdl_pkg::PCT_W-1:0];
                end
                wrdl_pkg::REG_LOWER_PCT: begin
                    cfg_next.lower_pct = cfg_data[wrdl_pkg::PCT_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.k_min         <= wrdl_pkg::K_MIN_RST;
            cfg_reg.k_max         <= wrdl_pkg::K_MAX_RST;
            cfg_reg.k_start       <= wrdl_pkg::K_START_RST;
            cfg_reg.warmup_tokens <= wrdl_pkg::WARMUP_RST;
            cfg_reg.raise_pct     <= wrdl_pkg::RAISE_PCT_RST;
            cfg_reg.lower_pct     <= wrdl_pkg::LOWER_PCT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/wrdl_window.sv
// Window memory, slot and fill tracking, warmup counter and running sums.
// Depends on wrdl_pkg; feeds window sums to wrdl_adjust through a struct.
module wrdl_window (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [wrdl_pkg::CNT_W-1:0] s_proposed,
    input  logic [wrdl_pkg::CNT_W-1:0] s_accepted,
    input  wrdl_pkg::cfg_t             cfg,
    input  logic                       adj_ready,
    output wrdl_pkg::win_status_t      status
);

    localparam int ENTRY_W = 2 * wrdl_pkg::CNT_W;

    logic [ENTRY_W-1:0] mem [wrdl_pkg::WINDOW_LEN];

    logic [wrdl_pkg::SLOT_W-1:0] slot_reg;
    logic [wrdl_pkg::SLOT_W-1:0] slot_next;
    logic [wrdl_pkg::FILL_W-1:0] fill_reg;
    logic [wrdl_pkg::FILL_W-1:0] fill_next;
    logic [wrdl_pkg::WARM_W-1:0] warm_reg;
    logic [wrdl_pkg::WARM_W-1:0] warm_next;
    logic [wrdl_pkg::WARM_W:0]   warm_sum;

    logic [wrdl_pkg::CNT_W-1:0] acc_clamp;
    logic                       rejected;

    logic                        s1_valid_reg;
    logic [wrdl_pkg::CNT_W-1:0]  prop1_reg;
    logic [wrdl_pkg::CNT_W-1:0]  acc1_reg;
    logic [wrdl_pkg::SLOT_W-1:0] slot1_reg;
    logic                        old_valid1_reg;
    logic                        en1_reg;
    logic [ENTRY_W-1:0]          rdata_reg;
    logic                        fwd_hit_reg;
    logic [ENTRY_W-1:0]          fwd_data_reg;

    logic                       s2_valid_reg;
    logic                       en2_reg;
    logic [wrdl_pkg::SUM_W-1:0] prop_sum_reg;
    logic [wrdl_pkg::SUM_W-1:0] prop_sum_next;
    logic [wrdl_pkg::SUM_W-1:0] acc_sum_reg;
    logic [wrdl_pkg::SUM_W-1:0] acc_sum_next;

    logic               accept;
    logic               s1_fire;
    logic               s2_fire;
    logic [ENTRY_W-1:0] old_entry;
    logic [wrdl_pkg::CNT_W-1:0] old_prop;
    logic [wrdl_pkg::CNT_W-1:0] old_acc;

    assign s2_fire = s2_valid_reg && adj_ready;
    assign s1_fire = s1_valid_reg && (!s2_valid_reg || s2_fire);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign accept  = s_valid && s_ready;

    always_comb begin
        acc_clamp = (s_accepted > s_proposed) ? s_proposed : s_accepted;
        rejected  = s_proposed > acc_clamp;
        warm_sum  = {1'b0, warm_reg} + (wrdl_pkg::WARM_W + 1)'(acc_clamp)
                  + (wrdl_pkg::WARM_W + 1)'(rejected);
        warm_next = (warm_sum > {1'b0, wrdl_pkg::WARM_MAX}) ? wrdl_pkg::WARM_MAX
                                                              : warm_sum[wrdl_pkg::WARM_W-1:0];
        slot_next = (slot_reg == wrdl_pkg::SLOT_LAST) ? '0
                                                      : slot_reg + wrdl_pkg::SLOT_W'(1);
        fill_next = (fill_reg < wrdl_pkg::FILL_FULL) ? fill_reg + wrdl_pkg::FILL_W'(1)
                                                     : fill_reg;
    end

    always_comb begin
        old_entry     = fwd_hit_reg ? fwd_data_reg : rdata_reg;
        old_prop      = old_valid1_reg ? old_entry[ENTRY_W-1:wrdl_pkg::CNT_W] : '0;
        old_acc       = old_valid1_reg ? old_entry[wrdl_pkg::CNT_W-1:0] : '0;
        prop_sum_next = prop_sum_reg - wrdl_pkg::SUM_W'(old_prop)
                      + wrdl_pkg::SUM_W'(prop1_reg);
        acc_sum_next  = acc_sum_reg - wrdl_pkg::SUM_W'(old_acc)
                      + wrdl_pkg::SUM_W'(acc1_reg);
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg <= mem[slot_reg];
        end
        if (s1_fire) begin
            mem[slot1_reg] <= {prop1_reg, acc1_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prop1_reg      <= s_proposed;
            acc1_reg       <= acc_clamp;
            slot1_reg      <= slot_reg;
            old_valid1_reg <= (fill_reg == wrdl_pkg::FILL_FULL);
            en1_reg        <= (warm_next >= cfg.warmup_tokens)
                           && (fill_next == wrdl_pkg::FILL_FULL);
            fwd_hit_reg    <= s1_fire && (slot1_reg == slot_reg);
            fwd_data_reg   <= {prop1_reg, acc1_reg};
        end
        if (s1_fire) begin
            en2_reg <= en1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            fill_reg     <= '0;
            warm_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            prop_sum_reg <= '0;
            acc_sum_reg  <= '0;
        end else begin
            if (accept) begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
                warm_reg <= warm_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                s2_valid_reg <= 1'b1;
                prop_sum_reg <= prop_sum_next;
                acc_sum_reg  <= acc_sum_next;
            end else if (s2_fire) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    assign status.valid     = s2_valid_reg;
    assign status.adjust_en = en2_reg;
    assign status.prop_sum  = prop_sum_reg;
    assign status.acc_sum   = acc_sum_reg;

endmodule

>>> sv/wrdl_adjust.sv
// Rate comparison, length register and result register of the controller.
// Depends on wrdl_pkg; takes window sums from wrdl_window.
module wrdl_adjust (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  wrdl_pkg::win_status_t      status,
    input  wrdl_pkg::cfg_t             cfg,
    input  wrdl_pkg::k_load_t          k_load,
    output logic                       adj_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [wrdl_pkg::K_W-1:0]   m_k_now,
    output logic [wrdl_pkg::DIR_W-1:0] m_direction
);

    logic [wrdl_pkg::K_W-1:0] k_reg;
    logic [wrdl_pkg::K_W-1:0] k_next;
    logic                     out_valid_reg;
    logic [wrdl_pkg::K_W-1:0] k_out_reg;
    wrdl_pkg::dir_t           dir_out_reg;
    wrdl_pkg::dir_t           dir_next;

    logic [wrdl_pkg::PROD_W-1:0] acc_scaled;
    logic [wrdl_pkg::PROD_W-1:0] raise_limit;
    logic [wrdl_pkg::PROD_W-1:0] lower_limit;
    logic                        above;
    logic                        below;
    logic                        fire;

    assign adj_ready = !out_valid_reg || m_ready;
    assign fire      = status.valid && adj_ready;

    always_comb begin
        acc_scaled  = wrdl_pkg::PROD_W'(status.acc_sum)
                    * wrdl_pkg::PROD_W'(wrdl_pkg::PCT_HUNDRED);
        raise_limit = wrdl_pkg::PROD_W'(cfg.raise_pct) * wrdl_pkg::PROD_W'(status.prop_sum);
        lower_limit = wrdl_pkg::PROD_W'(cfg.lower_pct) * wrdl_pkg::PROD_W'(status.prop_sum);
        above       = acc_scaled > raise_limit;
        if (status.prop_sum == '0) begin
            below = cfg.lower_pct != '0;
        end else begin
            below = acc_scaled < lower_limit;
        end
    end

    always_comb begin
        k_next   = k_reg;
        dir_next = wrdl_pkg::DIR_SAME;
        if (status.adjust_en && above && (k_reg < cfg.k_max)) begin
            k_next   = k_reg + wrdl_pkg::K_W'(1);
            dir_next = wrdl_pkg::DIR_UP;
        end else if (status.adjust_en && below && (k_reg > cfg.k_min)) begin
            k_next   = k_reg - wrdl_pkg::K_W'(1);
            dir_next = wrdl_pkg::DIR_DOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            k_out_reg   <= k_next;
            dir_out_reg <= dir_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg         <= wrdl_pkg::K_START_RST;
            out_valid_reg <= 1'b0;
        end else begin
            if (k_load.load) begin
                k_reg <= k_load.value;
            end else if (fire) begin
                k_reg <= k_next;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_k_now     = k_out_reg;
    assign m_direction = dir_out_reg;

endmodule

>>> sv/wrdl_checker.sv
// Port-level checker of the speculation-length controller, bound to the top level.
// Depends on wrdl_pkg and window_rate_draft_length_ctrl_top_macros.svh.
`include "window_rate_draft_length_ctrl_top_macros.svh"

module wrdl_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [wrdl_pkg::CNT_W-1:0]  s_proposed,
    input logic [wrdl_pkg::CNT_W-1:0]  s_accepted,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [wrdl_pkg::K_W-1:0]    m_k_now,
    input logic [wrdl_pkg::DIR_W-1:0]  m_direction,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [wrdl_pkg::IDX_W-1:0]  cfg_index,
    input logic [wrdl_pkg::DATA_W-1:0] cfg_data
);

    `WRDL_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_k_now) && $stable(m_direction), "Result word changed while stalled.")
    `WRDL_ASSERT_SAME(a_dir_code, m_valid, m_direction == wrdl_pkg::DIR_SAME || m_direction == wrdl_pkg::DIR_UP || m_direction == wrdl_pkg::DIR_DOWN, "Result direction code is undefined.")
    `WRDL_ASSERT_DELAY(a_latency, s_valid && s_ready, 3, m_valid, "No result word three cycles after an input word.")

endmodule

bind window_rate_draft_length_ctrl_top wrdl_checker u_wrdl_checker (.*);

>>> tb/wrdl_length_monitor.sv
`timescale 1ns / 1ps
// Checker for the speculation-length controller: follows register writes and rounds,
// predicts each length update and compares it with the result channel. Uses wrdl_pkg.
module wrdl_length_monitor
    import wrdl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [CNT_W-1:0]  s_proposed,
    input  logic [CNT_W-1:0]  s_accepted,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [K_W-1:0]    m_k_now,
    input  logic [DIR_W-1:0]  m_direction,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output int                mismatch_count,
    output int                outstanding,
    output int                updates_checked
);

    typedef struct packed {
        logic [K_W-1:0] k_now;
        dir_t           direction;
    } length_update_t;

    cfg_t              regs;
    logic [K_W-1:0]    k_cur;
    logic [CNT_W-1:0]  proposed_hist [WINDOW_LEN];
    logic [CNT_W-1:0]  accepted_hist [WINDOW_LEN];
    int                slot;
    int                filled;
    logic [WARM_W-1:0] warm_tokens;
    logic [SUM_W-1:0]  proposed_total;
    logic [SUM_W-1:0]  accepted_total;
    length_update_t    due_updates [$];
    int                fails = 0;
    int                checks = 0;

    function automatic length_update_t next_length(input logic [CNT_W-1:0] prop,
                                                   input logic [CNT_W-1:0] acc_in);
        logic [CNT_W-1:0] acc;
        int               warm_sum;
        logic             rise;
        logic             fall;
        length_update_t   upd;
        acc = (acc_in > prop) ? prop : acc_in;
        warm_sum = int'(warm_tokens) + int'(acc) + ((prop > acc) ? 1 : 0);
        warm_tokens = (warm_sum > int'(WARM_MAX)) ? WARM_MAX : WARM_W'(warm_sum);
        proposed_total = proposed_total - proposed_hist[slot] + prop;
        accepted_total = accepted_total - accepted_hist[slot] + acc;
        proposed_hist[slot] = prop;
        accepted_hist[slot] = acc;
        slot = (slot + 1) % WINDOW_LEN;
        if (filled < WINDOW_LEN) begin
            filled++;
        end
        upd.direction = DIR_SAME;
        if (warm_tokens >= regs.warmup_tokens && filled >= WINDOW_LEN) begin
            rise = 100 * int'(accepted_total) > int'(regs.raise_pct) * int'(proposed_total);
            if (proposed_total == '0) begin
                fall = (regs.lower_pct != '0);
            end else begin
                fall = 100 * int'(accepted_total) <
                       int'(regs.lower_pct) * int'(proposed_total);
            end
            if (rise && k_cur < regs.k_max) begin
                k_cur = k_cur + 1'b1;
                upd.direction = DIR_UP;
            end else if (fall && k_cur > regs.k_min) begin
                k_cur = k_cur - 1'b1;
                upd.direction = DIR_DOWN;
            end
        end
        upd.k_now = k_cur;
        return upd;
    endfunction

    always @(posedge aclk) begin
        length_update_t want;
        if (!aresetn) begin
            regs = '{k_min: K_MIN_RST, k_max: K_MAX_RST, k_start: K_START_RST,
                     warmup_tokens: WARMUP_RST, raise_pct: RAISE_PCT_RST,
                     lower_pct: LOWER_PCT_RST};
            k_cur = K_START_RST;
            foreach (proposed_hist[i]) begin
                proposed_hist[i] = '0;
                accepted_hist[i] = '0;
            end
            slot = 0;
            filled = 0;
            warm_tokens = '0;
            proposed_total = '0;
            accepted_total = '0;
            due_updates.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_K_MIN: begin
                        regs.k_min = cfg_data[K_W-1:0];
                    end
                    REG_K_MAX: begin
                        regs.k_max = cfg_data[K_W-1:0];
                    end
                    REG_K_START: begin
                        regs.k_start = cfg_data[K_W-1:0];
                        k_cur = cfg_data[K_W-1:0];
                    end
                    REG_WARMUP: begin
                        regs.warmup_tokens = cfg_data[WARM_W-1:0];
                    end
                    REG_RAISE_PCT: begin
                        regs.raise_pct = cfg_data[PCT_W-1:0];
                    end
                    REG_LOWER_PCT: begin
                        regs.lower_pct = cfg_data[PCT_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                due_updates.insert(due_updates.size(), next_length(s_proposed, s_accepted));
            end
            if (m_valid && m_ready) begin
                if (due_updates.size() == 0) begin
                    $error("Unexpected word: k_now %0d, direction %0d with no round pending",
                           m_k_now, m_direction);
                    fails++;
                end else begin
                    want = due_updates.pop_front();
                    checks++;
                    if (m_k_now !== want.k_now) begin
                        $error("k_now: expected %0d, got %0d", want.k_now, m_k_now);
                        fails++;
                    end
                    if (m_direction !== want.direction) begin
                        $error("direction: expected %0d, got %0d", want.direction, m_direction);
                        fails++;
                    end
                end
            end
        end
        mismatch_count <= fails;
        outstanding <= due_updates.size();
        updates_checked <= checks;
    end

endmodule

>>> tb/tb_window_rate_draft_length_ctrl_top.sv
`timescale 1ns / 1ps
// Testbench top of the speculation-length controller: drives rounds and register
// writes with random gaps and stalls, and gives the verdict. Uses wrdl_pkg and wrdl_length_monitor.
module tb_window_rate_draft_length_ctrl_top;
    import wrdl_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(7);

    typedef enum {MOSTLY_ACCEPTED, MOSTLY_REJECTED, ANY_MIX} accept_bias_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [CNT_W-1:0]  s_proposed;
    logic [CNT_W-1:0]  s_accepted;
    logic              m_valid;
    logic              m_ready;
    logic [K_W-1:0]    m_k_now;
    logic [DIR_W-1:0]  m_direction;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;
    int                mismatch_count;
    int                outstanding;
    int                updates_checked;
    int                rounds_sent = 0;
    int                reg_writes = 0;
    int                settings_used = 1;
    int                s_calm = 0;
    int                m_calm = 0;
    int                idle_cycles = 0;

    logic [2*CNT_W-1:0] directed_rounds [24] = '{
        8'h00, 8'hFF, 8'hF0, 8'h0F, 8'h59, 8'h95, 8'h11, 8'h10,
        8'h88, 8'hA3, 8'h66, 8'hCB, 8'h33, 8'h40, 8'hFE, 8'h22,
        8'h77, 8'hBB, 8'hDD, 8'hEE, 8'h99, 8'hFF, 8'hFF, 8'hFF
    };

    always #2 aclk = ~aclk;

    window_rate_draft_length_ctrl_top dut (.*);

    wrdl_length_monitor length_mon (.*);

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic send_round(input logic [CNT_W-1:0] prop, input logic [CNT_W-1:0] acc);
        int gap = draw_gap(s_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_proposed <= prop;
        s_accepted <= acc;
        do @(posedge aclk); while (s_ready !== 1'b1);
        rounds_sent++;
    endtask

    task automatic run_rounds(input int count, input accept_bias_t bias, input bit zero_run);
        int prop;
        int acc;
        for (int i = 0; i < count; i++) begin
            prop = $urandom_range(0, 15);
            case (bias)
                MOSTLY_ACCEPTED: begin
                    acc = prop - int'($urandom_range(0, prop / 6));
                end
                MOSTLY_REJECTED: begin
                    acc = $urandom_range(0, prop / 3);
                end
                default: begin
                    acc = $urandom_range(0, 15);
                end
            endcase
            if ($urandom_range(0, 11) == 0) begin
                acc = $urandom_range(prop, 15);
            end
            if (zero_run && i >= 20 && i < 50) begin
                prop = 0;
            end
            send_round(CNT_W'(prop), CNT_W'(acc));
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        reg_writes++;
    endtask

    task automatic set_lengths(input logic [K_W-1:0] k_lo, input logic [K_W-1:0] k_hi,
                               input logic [K_W-1:0] k_init, input logic [WARM_W-1:0] warm,
                               input logic [PCT_W-1:0] raise, input logic [PCT_W-1:0] lower);
        write_reg(REG_K_MIN, {4'($urandom), k_lo});
        write_reg(REG_K_MAX, {4'($urandom), k_hi});
        write_reg(REG_K_START, {4'($urandom), k_init});
        write_reg(REG_WARMUP, warm);
        write_reg(REG_RAISE_PCT, {1'($urandom), raise});
        write_reg(REG_LOWER_PCT, {1'($urandom), lower});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = draw_gap(m_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("window_rate_draft_length_ctrl_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_proposed <= '0;
        s_accepted <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rounds[i]) begin
            send_round(directed_rounds[i][7:4], directed_rounds[i][3:0]);
        end
        run_rounds(60, MOSTLY_ACCEPTED, 1'b0);

        drain();
        set_lengths(4'd1, 4'd15, 4'd1, 8'd0, 7'd0, 7'd0);
        run_rounds(70, ANY_MIX, 1'b1);

        drain();
        set_lengths(4'd15, 4'd15, 4'd15, 8'd255, 7'd100, 7'd100);
        run_rounds(60, MOSTLY_ACCEPTED, 1'b0);

        // Bounds swapped: the increase test still takes precedence.
        drain();
        set_lengths(4'd12, 4'd3, 4'd8, 8'd10, 7'd60, 7'd70);
        run_rounds(70, MOSTLY_REJECTED, 1'b1);

        // Start above the upper bound with thresholds past one hundred percent.
        drain();
        set_lengths(4'd5, 4'd9, 4'd15, 8'd0, 7'd127, 7'd127);
        run_rounds(60, ANY_MIX, 1'b0);

        // Threshold-only update: the current length and the window must carry over.
        drain();
        write_reg(REG_RAISE_PCT, 8'd50);
        write_reg(REG_LOWER_PCT, 8'd40);
        write_reg(REG_SPARE_LO, DATA_W'($urandom));
        write_reg(REG_SPARE_HI, DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings_used++;
        run_rounds(60, MOSTLY_ACCEPTED, 1'b0);

        drain();
        set_lengths(4'd1, 4'd15, 4'd4, 8'd0, 7'd85, 7'd55);
        run_rounds(40, MOSTLY_REJECTED, 1'b0);
        run_rounds(40, MOSTLY_ACCEPTED, 1'b0);

        repeat (2) begin
            drain();
            set_lengths(K_W'($urandom_range(1, 15)), K_W'($urandom_range(1, 15)),
                        K_W'($urandom_range(1, 15)), WARM_W'($urandom),
                        PCT_W'($urandom_range(0, 100)), PCT_W'($urandom_range(0, 100)));
            run_rounds(40, accept_bias_t'($urandom_range(0, 2)), 1'($urandom));
        end

        drain();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d rounds and %0d register writes across %0d settings;",
                 rounds_sent, reg_writes, settings_used);
        $display("%0d length updates were compared against the prediction.", updates_checked);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("window_rate_draft_length_ctrl_top verification clean");
        end else begin
            $display("window_rate_draft_length_ctrl_top verification failed");
        end
        $finish;
    end

endmodule
